FILE: hdl/rc_stuffed_frame_decoder_defines.svh
// assertion macros for the rc stuffed frame decoder checks
`ifndef RC_STUFFED_FRAME_DECODER_DEFINES_SVH
`define RC_STUFFED_FRAME_DECODER_DEFINES_SVH

// property checked while out of reset
`define RCSFD_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define RCSFD_CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/rcsfd_pkg.sv
// shared constants, job type and channel scaling for the rc frame decoder
package rcsfd_pkg;

    localparam int FRAME_BYTES   = 29;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CHANNEL_COUNT = 16;
    localparam int CHAN_BITS     = 11;
    localparam int CHAN_IDX_W    = 4;
    localparam int VALUE_W       = 12;
    localparam int PAY_BITS      = CHANNEL_COUNT * CHAN_BITS;
    localparam int PAY_BYTES     = PAY_BITS / 8;
    localparam int PAY_IDX_W     = $clog2(PAY_BYTES);
    localparam int SUM_W         = 13;

    localparam int POS_LEN   = 1;
    localparam int POS_TYPE  = 2;
    localparam int POS_PRIM  = 3;
    localparam int PAY_FIRST = 3;
    localparam int POS_FLAGS = 25;
    localparam int POS_RSSI  = 26;
    localparam int FS_BIT    = 3;

    localparam logic [7:0] HEAD_BYTE     = 8'h7E;
    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] ESC_XOR       = 8'h20;
    localparam logic [7:0] LEN_CONTROL   = 8'h19;
    localparam logic [7:0] LEN_DOWNLINK  = 8'h08;
    localparam logic [7:0] TYPE_CONTROL  = 8'h00;
    localparam logic [7:0] TYPE_DOWNLINK = 8'h01;
    localparam logic [7:0] PRIM_POLL     = 8'h00;
    localparam logic [7:0] PRIM_POLL_ALT = 8'h10;
    localparam logic [8:0] SUM_GOOD      = 9'h0FF;

    localparam int CTRL_END = 29;
    localparam int DL_END   = 12;

    localparam logic [VALUE_W-1:0] CHANNEL_OFFSET = 12'd874;

    localparam logic KIND_CONTROL = 1'b0;
    localparam logic KIND_POLL    = 1'b1;

    localparam int          ADDR_W        = 3;
    localparam int          DATA_W        = 32;
    localparam logic        REG_FRAME_GAP = 1'b0;
    localparam logic [15:0] GAP_RESET     = 16'd2000;

    typedef struct packed {
        logic                kind;
        logic                failsafe;
        logic [7:0]          rssi;
        logic [PAY_BITS-1:0] bits;
    } t_job;

    function automatic logic [VALUE_W-1:0] scale_channel(input logic [CHAN_BITS-1:0] raw);
        logic [13:0] prod;
        prod = 14'({raw, 2'b00}) + 14'(raw) + 14'd4;
        return 12'(prod[13:3]) + CHANNEL_OFFSET;
    endfunction

endpackage

FILE: hdl/rcsfd_front.sv
// front end: gap detection, unstuffing, frame assembly and checksum
module rcsfd_front #(
    parameter int FRAME_BYTES = rcsfd_pkg::FRAME_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_frame_gap_us,
    input  logic              i_in_valid,
    input  logic [7:0]        i_byte_value,
    input  logic [31:0]       i_time_us,
    input  logic              i_queue_full,
    output logic              o_push,
    output rcsfd_pkg::t_job   o_job
);

    localparam int PW = $clog2(FRAME_BYTES);
    localparam int CW = PW + 1;

    logic [PW-1:0]              r_pos;
    logic                       r_esc;
    logic [31:0]                r_last_time;
    logic [7:0]                 r_len;
    logic [7:0]                 r_type;
    logic [7:0]                 r_prim;
    logic                       r_fs;
    logic [7:0]                 r_rssi;
    logic [rcsfd_pkg::SUM_W-1:0] r_sum;
    logic [7:0]                 r_pay [rcsfd_pkg::PAY_BYTES];

    logic                       accept;
    logic [31:0]                elapsed;
    logic                       gap;
    logic [PW-1:0]              cur_pos;
    logic                       cur_esc;
    logic                       drop_head;
    logic                       start_esc;
    logic                       store;
    logic [7:0]                 data;
    logic [CW-1:0]              next_cnt;
    logic [7:0]                 len_now;
    logic [7:0]                 type_now;
    logic                       bad;
    logic                       ctrl_end;
    logic                       dl_end;
    logic                       full_end;
    logic                       restart;
    logic [8:0]                 folded;
    logic                       sum_good;
    logic                       prim_ok;
    logic [rcsfd_pkg::PAY_IDX_W-1:0] pay_idx;
    logic                       in_pay;
    logic [rcsfd_pkg::PAY_BITS-1:0]  pay_bits;

    always_comb begin
        accept    = i_in_valid && !i_queue_full;
        elapsed   = i_time_us - r_last_time;
        gap       = elapsed >= {16'b0, i_frame_gap_us};
        cur_pos   = gap ? '0 : r_pos;
        cur_esc   = gap ? 1'b0 : r_esc;
        drop_head = (cur_pos == '0) && (i_byte_value != rcsfd_pkg::HEAD_BYTE);
        start_esc = !cur_esc && (i_byte_value == rcsfd_pkg::ESC_BYTE);
        store     = !drop_head && !start_esc;
        data      = cur_esc ? (i_byte_value ^ rcsfd_pkg::ESC_XOR) : i_byte_value;
        next_cnt  = {1'b0, cur_pos} + CW'(1);
        len_now   = (cur_pos == PW'(rcsfd_pkg::POS_LEN)) ? data : r_len;
        type_now  = (cur_pos == PW'(rcsfd_pkg::POS_TYPE)) ? data : r_type;

        bad = ((cur_pos == PW'(rcsfd_pkg::POS_LEN))
                  && (len_now != rcsfd_pkg::LEN_CONTROL)
                  && (len_now != rcsfd_pkg::LEN_DOWNLINK))
           || ((cur_pos == PW'(rcsfd_pkg::POS_TYPE))
                  && (((type_now == rcsfd_pkg::TYPE_CONTROL)
                          && (len_now != rcsfd_pkg::LEN_CONTROL))
                   || ((type_now == rcsfd_pkg::TYPE_DOWNLINK)
                          && (len_now != rcsfd_pkg::LEN_DOWNLINK))));
        ctrl_end = !bad && (type_now == rcsfd_pkg::TYPE_CONTROL)
                && (next_cnt == CW'(rcsfd_pkg::CTRL_END));
        dl_end   = !bad && (type_now == rcsfd_pkg::TYPE_DOWNLINK)
                && (next_cnt == CW'(rcsfd_pkg::DL_END));
        full_end = !bad && !ctrl_end && !dl_end && (next_cnt >= CW'(FRAME_BYTES));
        restart  = bad || ctrl_end || dl_end || full_end;

        // checksum folded once, current byte is the unexamined end byte
        folded   = {1'b0, r_sum[7:0]} + 9'(r_sum[rcsfd_pkg::SUM_W-1:8]);
        sum_good = folded == rcsfd_pkg::SUM_GOOD;
        prim_ok  = (r_prim == rcsfd_pkg::PRIM_POLL) || (r_prim == rcsfd_pkg::PRIM_POLL_ALT);

        in_pay  = (cur_pos >= PW'(rcsfd_pkg::PAY_FIRST))
               && ({1'b0, cur_pos} < CW'(rcsfd_pkg::PAY_FIRST + rcsfd_pkg::PAY_BYTES));
        pay_idx = rcsfd_pkg::PAY_IDX_W'(cur_pos - PW'(rcsfd_pkg::PAY_FIRST));

        for (int j = 0; j < rcsfd_pkg::PAY_BYTES; j++) begin
            pay_bits[8*j +: 8] = r_pay[j];
        end

        o_push = accept && store
              && ((ctrl_end && sum_good) || (dl_end && sum_good && prim_ok));
        o_job.kind     = dl_end ? rcsfd_pkg::KIND_POLL : rcsfd_pkg::KIND_CONTROL;
        o_job.failsafe = dl_end ? 1'b0 : r_fs;
        o_job.rssi     = dl_end ? 8'd0 : r_rssi;
        o_job.bits     = pay_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_esc       <= 1'b0;
            r_last_time <= '0;
        end else if (accept) begin
            r_last_time <= i_time_us;
            if (drop_head) begin
                r_pos <= '0;
                r_esc <= 1'b0;
            end else if (start_esc) begin
                r_pos <= cur_pos;
                r_esc <= 1'b1;
            end else begin
                r_esc <= 1'b0;
                r_pos <= restart ? '0 : next_cnt[PW-1:0];
            end
        end
    end

    // frame contents, written only within the current frame before use
    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            if (cur_pos == PW'(rcsfd_pkg::POS_LEN)) begin
                r_len <= data;
                r_sum <= rcsfd_pkg::SUM_W'(data);
            end else if (cur_pos >= PW'(rcsfd_pkg::POS_TYPE)) begin
                r_sum <= r_sum + rcsfd_pkg::SUM_W'(data);
            end
            if (cur_pos == PW'(rcsfd_pkg::POS_TYPE)) begin
                r_type <= data;
            end
            if (cur_pos == PW'(rcsfd_pkg::POS_PRIM)) begin
                r_prim <= data;
            end
            if (cur_pos == PW'(rcsfd_pkg::POS_FLAGS)) begin
                r_fs <= data[rcsfd_pkg::FS_BIT];
            end
            if (cur_pos == PW'(rcsfd_pkg::POS_RSSI)) begin
                r_rssi <= data;
            end
            if (in_pay) begin
                r_pay[pay_idx] <= data;
            end
        end
    end

endmodule

FILE: hdl/rcsfd_queue.sv
// short job queue between frame assembly and result output
module rcsfd_queue #(
    parameter int DEPTH = rcsfd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rcsfd_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output rcsfd_pkg::t_job o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    rcsfd_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [NW-1:0]   r_cnt;

    logic            do_push;
    logic            do_pop;

    always_comb begin
        o_full  = r_cnt == NW'(DEPTH);
        o_empty = r_cnt == '0;
        o_head  = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: hdl/rcsfd_back.sv
// back end: unpacks channels of one job and drives the result register
module rcsfd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  rcsfd_pkg::t_job                     i_head,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_kind,
    output logic [rcsfd_pkg::CHAN_IDX_W-1:0]    o_channel_index,
    output logic [rcsfd_pkg::VALUE_W-1:0]       o_channel_value,
    output logic                                o_failsafe,
    output logic [7:0]                          o_rssi,
    output logic                                o_last
);

    logic                                r_busy;
    logic [rcsfd_pkg::CHAN_IDX_W-1:0]    r_cnt;
    logic                                r_kind;
    logic                                r_fs;
    logic [7:0]                          r_rssi;
    logic [rcsfd_pkg::PAY_BITS-1:0]      r_bits;

    logic                                r_out_valid;
    logic                                r_o_kind;
    logic [rcsfd_pkg::CHAN_IDX_W-1:0]    r_o_idx;
    logic [rcsfd_pkg::VALUE_W-1:0]       r_o_value;
    logic                                r_o_fs;
    logic [7:0]                          r_o_rssi;
    logic                                r_o_last;

    logic                                emit;
    logic                                done;
    logic                                is_poll;

    always_comb begin
        o_pop   = !r_busy && !i_empty;
        emit    = r_busy && (!r_out_valid || !i_out_stall);
        is_poll = r_kind == rcsfd_pkg::KIND_POLL;
        done    = is_poll || (r_cnt == rcsfd_pkg::CHAN_IDX_W'(rcsfd_pkg::CHANNEL_COUNT - 1));

        o_out_valid     = r_out_valid;
        o_kind          = r_o_kind;
        o_channel_index = r_o_idx;
        o_channel_value = r_o_value;
        o_failsafe      = r_o_fs;
        o_rssi          = r_o_rssi;
        o_last          = r_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && done) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cnt  <= '0;
            r_kind <= i_head.kind;
            r_fs   <= i_head.failsafe;
            r_rssi <= i_head.rssi;
            r_bits <= i_head.bits;
        end else if (emit) begin
            r_cnt  <= r_cnt + rcsfd_pkg::CHAN_IDX_W'(1);
            r_bits <= r_bits >> rcsfd_pkg::CHAN_BITS;
        end
        if (emit) begin
            r_o_kind  <= r_kind;
            r_o_idx   <= is_poll ? '0 : r_cnt;
            r_o_value <= is_poll ? '0
                       : rcsfd_pkg::scale_channel(r_bits[rcsfd_pkg::CHAN_BITS-1:0]);
            r_o_fs    <= is_poll ? 1'b0 : r_fs;
            r_o_rssi  <= is_poll ? 8'd0 : r_rssi;
            r_o_last  <= done;
        end
    end

endmodule

FILE: hdl/rc_stuffed_frame_decoder.sv
// top level: byte-stuffed rc frame decoder with frame gap register
// one byte per cycle is taken; input stalls only while the two-entry job queue is full
// the first result of a good frame passes through the job queue, the unpacker job register and the result register
// a control frame gives sixteen results, one per cycle while the output is not stalled, set by the channel unpacker
// synchronous active-low reset clears frame assembly, the arrival time, the queue and the channel unpacker;
// the frame gap register returns to 2000 us
module rc_stuffed_frame_decoder #(
    parameter int FRAME_BYTES = rcsfd_pkg::FRAME_BYTES,
    parameter int QUEUE_DEPTH = rcsfd_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rcsfd_pkg::ADDR_W-1:0]        paddr,
    input  logic [rcsfd_pkg::DATA_W-1:0]        pwdata,
    output logic [rcsfd_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_byte_value,
    input  logic [31:0]                         i_time_us,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_kind,
    output logic [rcsfd_pkg::CHAN_IDX_W-1:0]    o_channel_index,
    output logic [rcsfd_pkg::VALUE_W-1:0]       o_channel_value,
    output logic                                o_failsafe,
    output logic [7:0]                          o_rssi,
    output logic                                o_last
);

    logic [15:0]     r_frame_gap_us;
    logic            reg_sel;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    rcsfd_pkg::t_job job_in;
    rcsfd_pkg::t_job job_head;

    always_comb begin
        pready     = 1'b1;
        reg_sel    = paddr[2] == rcsfd_pkg::REG_FRAME_GAP;
        prdata     = reg_sel ? {16'b0, r_frame_gap_us} : '0;
        o_in_stall = full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_gap_us <= rcsfd_pkg::GAP_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_frame_gap_us <= pwdata[15:0];
        end
    end

    rcsfd_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_gap_us (r_frame_gap_us),
        .i_in_valid     (i_in_valid),
        .i_byte_value   (i_byte_value),
        .i_time_us      (i_time_us),
        .i_queue_full   (full),
        .o_push         (push),
        .o_job          (job_in)
    );

    rcsfd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (job_head)
    );

    rcsfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_head          (job_head),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_failsafe      (o_failsafe),
        .o_rssi          (o_rssi),
        .o_last          (o_last)
    );

endmodule

FILE: hdl/rcsfd_checker.sv
// port checks for the rc frame decoder and their bind
`include "rc_stuffed_frame_decoder_defines.svh"

module rcsfd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_kind,
    input logic [rcsfd_pkg::CHAN_IDX_W-1:0]    o_channel_index,
    input logic [rcsfd_pkg::VALUE_W-1:0]       o_channel_value,
    input logic                                o_last
);

    `RCSFD_CHECK(a_stall_holds, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_channel_value) && $stable(o_channel_index) && $stable(o_last), "stalled result beat changed")
    `RCSFD_CHECK(a_value_range, o_out_valid && (o_kind == rcsfd_pkg::KIND_CONTROL) |-> (o_channel_value >= 12'd874) && (o_channel_value <= 12'd2153), "channel value out of range")
    `RCSFD_CHECK(a_poll_shape, o_out_valid && (o_kind == rcsfd_pkg::KIND_POLL) |-> o_last && (o_channel_index == '0) && (o_channel_value == '0), "malformed poll beat")
    `RCSFD_CHECK(a_last_index, o_out_valid && (o_kind == rcsfd_pkg::KIND_CONTROL) |-> (o_last == (o_channel_index == 4'd15)), "last flag not on final channel")
    `RCSFD_CHECK_ALWAYS(a_next_channel, i_rst_n && o_out_valid && !i_out_stall && (o_kind == rcsfd_pkg::KIND_CONTROL) && !o_last |=> !i_rst_n || (o_out_valid && (o_channel_index == $past(o_channel_index) + 4'd1)), "channel burst broken")

endmodule

bind rc_stuffed_frame_decoder rcsfd_checker u_rcsfd_checker (.*);

FILE: tb/tb.sv
// self-checking testbench for the rc stuffed frame decoder
module tb;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0]  value;
        logic [31:0] stamp;
    } t_rx_byte;

    typedef struct packed {
        logic                            kind;
        logic [rcsfd_pkg::CHAN_IDX_W-1:0] chan;
        logic [rcsfd_pkg::VALUE_W-1:0]    value;
        logic                            failsafe;
        logic [7:0]                      rssi;
        logic                            last;
    } t_chan_result;

    typedef enum int {
        SHAPE_CONTROL,
        SHAPE_POLL,
        SHAPE_DOWNLINK,
        SHAPE_BAD_SUM,
        SHAPE_BAD_LEN,
        SHAPE_BAD_TYPE,
        SHAPE_UNKNOWN_TYPE,
        SHAPE_CUT,
        SHAPE_NOISE
    } t_frame_shape;

    logic                             i_clk          = 1'b0;
    logic                             i_rst_n        = 1'b0;
    logic                             psel           = 1'b0;
    logic                             penable        = 1'b0;
    logic                             pwrite         = 1'b0;
    logic [rcsfd_pkg::ADDR_W-1:0]     paddr          = '0;
    logic [rcsfd_pkg::DATA_W-1:0]     pwdata         = '0;
    logic [rcsfd_pkg::DATA_W-1:0]     prdata;
    logic                             pready;
    logic                             i_in_valid     = 1'b0;
    logic                             o_in_stall;
    logic [7:0]                       i_byte_value   = '0;
    logic [31:0]                      i_time_us      = '0;
    logic                             o_out_valid;
    logic                             i_out_stall    = 1'b0;
    logic                             o_kind;
    logic [rcsfd_pkg::CHAN_IDX_W-1:0] o_channel_index;
    logic [rcsfd_pkg::VALUE_W-1:0]    o_channel_value;
    logic                             o_failsafe;
    logic [7:0]                       o_rssi;
    logic                             o_last;

    // decoder state kept by the testbench
    logic [15:0] cfg_gap     = rcsfd_pkg::GAP_RESET;
    logic [4:0]  frame_pos   = '0;
    logic        esc_pending = 1'b0;
    logic [31:0] last_stamp  = '0;
    logic [7:0]  frame_buf [rcsfd_pkg::FRAME_BYTES];

    t_chan_result pending_results [$];
    t_rx_byte     byte_feed [$];
    logic [7:0]   frame_body [$];

    int          bytes_queued = 0;
    int          bytes_taken  = 0;
    int          fail_count   = 0;
    int          cycle_count  = 0;
    int          feed_idle    = 0;
    int          out_idle     = 0;
    logic        feed_burst   = 1'b0;
    logic        out_burst    = 1'b0;
    logic [31:0] gen_stamp    = '0;
    logic        cut_pending  = 1'b0;

    rc_stuffed_frame_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_byte_value    (i_byte_value),
        .i_time_us       (i_time_us),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_failsafe      (o_failsafe),
        .o_rssi          (o_rssi),
        .o_last          (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic string describe(input t_chan_result r);
        return $sformatf("kind %0d ch %0d value %0d fs %0d rssi %0d last %0d",
                         r.kind, r.chan, r.value, r.failsafe, r.rssi, r.last);
    endfunction

    function automatic void log_failure(input string what, input t_chan_result want,
                                        input t_chan_result got);
        if (fail_count < MAX_REPORTS)
            $display("%s: expected %s, got %s", what, describe(want), describe(got));
        fail_count++;
    endfunction

    function automatic logic checksum_good();
        int total;
        total = 0;
        for (int i = rcsfd_pkg::POS_LEN;
                i <= int'(frame_buf[rcsfd_pkg::POS_LEN]) + 2; i++)
            total += frame_buf[i];
        total = total & 16'hFFFF;
        return ((total & 8'hFF) + (total >> 8)) == rcsfd_pkg::SUM_GOOD;
    endfunction

    function automatic void decode_byte(input logic [7:0] raw_byte, input logic [31:0] stamp);
        logic [7:0]   b;
        logic [31:0]  since;
        logic         drop;
        logic [23:0]  word;
        logic [10:0]  raw;
        int           bitpos;
        int           k;
        t_chan_result r;
        b = raw_byte;
        drop = 1'b0;
        since = stamp - last_stamp;
        if (since >= {16'd0, cfg_gap}) begin
            frame_pos = '0;
            esc_pending = 1'b0;
        end
        last_stamp = stamp;
        if (frame_pos == 0 && b != rcsfd_pkg::HEAD_BYTE)
            return;
        if (esc_pending) begin
            b = b ^ rcsfd_pkg::ESC_XOR;
            esc_pending = 1'b0;
        end else if (b == rcsfd_pkg::ESC_BYTE) begin
            esc_pending = 1'b1;
            return;
        end
        frame_buf[frame_pos] = b;
        frame_pos++;
        if (frame_pos == rcsfd_pkg::POS_LEN + 1
                && frame_buf[rcsfd_pkg::POS_LEN] != rcsfd_pkg::LEN_CONTROL
                && frame_buf[rcsfd_pkg::POS_LEN] != rcsfd_pkg::LEN_DOWNLINK)
            drop = 1'b1;
        if (frame_pos == rcsfd_pkg::POS_TYPE + 1
                && ((frame_buf[rcsfd_pkg::POS_TYPE] == rcsfd_pkg::TYPE_CONTROL
                        && frame_buf[rcsfd_pkg::POS_LEN] != rcsfd_pkg::LEN_CONTROL)
                    || (frame_buf[rcsfd_pkg::POS_TYPE] == rcsfd_pkg::TYPE_DOWNLINK
                        && frame_buf[rcsfd_pkg::POS_LEN] != rcsfd_pkg::LEN_DOWNLINK)))
            drop = 1'b1;
        if (!drop) begin
            if (frame_buf[rcsfd_pkg::POS_TYPE] == rcsfd_pkg::TYPE_CONTROL
                    && frame_pos == rcsfd_pkg::CTRL_END) begin
                if (checksum_good()) begin
                    for (int ch = 0; ch < rcsfd_pkg::CHANNEL_COUNT; ch++) begin
                        bitpos = rcsfd_pkg::CHAN_BITS * ch;
                        k = rcsfd_pkg::PAY_FIRST + bitpos / 8;
                        word = {frame_buf[k + 2], frame_buf[k + 1], frame_buf[k]};
                        raw = 11'(word >> (bitpos % 8));
                        r.kind = rcsfd_pkg::KIND_CONTROL;
                        r.chan = rcsfd_pkg::CHAN_IDX_W'(ch);
                        r.value = rcsfd_pkg::VALUE_W'(((int'(raw) * 5 + 4) >> 3)
                                + int'(rcsfd_pkg::CHANNEL_OFFSET));
                        r.failsafe = frame_buf[rcsfd_pkg::POS_FLAGS][rcsfd_pkg::FS_BIT];
                        r.rssi = frame_buf[rcsfd_pkg::POS_RSSI];
                        r.last = (ch == rcsfd_pkg::CHANNEL_COUNT - 1);
                        pending_results.push_back(r);
                    end
                end
                drop = 1'b1;
            end else if (frame_buf[rcsfd_pkg::POS_TYPE] == rcsfd_pkg::TYPE_DOWNLINK
                    && frame_pos == rcsfd_pkg::DL_END) begin
                if (checksum_good()
                        && (frame_buf[rcsfd_pkg::POS_PRIM] == rcsfd_pkg::PRIM_POLL
                        || frame_buf[rcsfd_pkg::POS_PRIM] == rcsfd_pkg::PRIM_POLL_ALT)) begin
                    r = '0;
                    r.kind = rcsfd_pkg::KIND_POLL;
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end
                drop = 1'b1;
            end else if (frame_pos >= rcsfd_pkg::FRAME_BYTES) begin
                drop = 1'b1;
            end
        end
        if (drop) begin
            frame_pos = '0;
            esc_pending = 1'b0;
        end
    endfunction

    // byte source
    always @(posedge i_clk) begin
        t_rx_byte beat;
        logic     hold;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            hold = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_byte_value, i_time_us);
                bytes_taken++;
                hold = 1'b0;
                if ($urandom_range(0, 31) == 0)
                    feed_burst = ~feed_burst;
                feed_idle = feed_burst ? 0 : $urandom_range(0, 15);
            end
            if (!hold) begin
                if (feed_idle != 0) begin
                    feed_idle--;
                    i_in_valid <= 1'b0;
                end else if (byte_feed.size() != 0) begin
                    beat = byte_feed.pop_front();
                    i_byte_value <= beat.value;
                    i_time_us <= beat.stamp;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin
        t_chan_result got;
        t_chan_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.kind = o_kind;
                got.chan = o_channel_index;
                got.value = o_channel_value;
                got.failsafe = o_failsafe;
                got.rssi = o_rssi;
                got.last = o_last;
                if (pending_results.size() == 0) begin
                    log_failure("unexpected result", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.chan !== want.chan
                            || got.value !== want.value || got.failsafe !== want.failsafe
                            || got.rssi !== want.rssi || got.last !== want.last)
                        log_failure("result mismatch", want, got);
                end
                if ($urandom_range(0, 31) == 0)
                    out_burst = ~out_burst;
                out_idle = out_burst ? 0 : $urandom_range(0, 15);
            end else if (out_idle != 0) begin
                out_idle--;
            end
            i_out_stall <= (out_idle != 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rc_stuffed_frame_decoder regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] next_stamp(input logic in_frame);
        logic [31:0] delta;
        int          span;
        if (in_frame && cfg_gap != 0) begin
            span = (cfg_gap > 300) ? 300 : int'(cfg_gap) - 1;
            delta = ($urandom_range(0, 7) == 0) ? cfg_gap - 1 : $urandom_range(0, span);
        end else if ($urandom_range(0, 7) == 0) begin
            delta = $urandom;
            if (delta < cfg_gap)
                delta = cfg_gap;
        end else begin
            delta = ($urandom_range(0, 5) == 0) ? cfg_gap : cfg_gap + $urandom_range(1, 5000);
        end
        gen_stamp = gen_stamp + delta;
        return gen_stamp;
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic in_frame);
        t_rx_byte beat;
        beat.value = value;
        beat.stamp = next_stamp(in_frame);
        byte_feed.push_back(beat);
        bytes_queued++;
    endtask

    task automatic queue_framed(input logic long_head);
        send_byte(rcsfd_pkg::HEAD_BYTE, !long_head);
        foreach (frame_body[i]) begin
            if (frame_body[i] == rcsfd_pkg::ESC_BYTE || (frame_body[i] == rcsfd_pkg::HEAD_BYTE
                    && $urandom_range(0, 3) == 0) || $urandom_range(0, 15) == 0) begin
                send_byte(rcsfd_pkg::ESC_BYTE, 1'b1);
                send_byte(frame_body[i] ^ rcsfd_pkg::ESC_XOR, 1'b1);
            end else begin
                send_byte(frame_body[i], 1'b1);
            end
        end
    endtask

    task automatic build_control();
        int fill;
        fill = $urandom_range(0, 3);
        frame_body.delete();
        frame_body.push_back(rcsfd_pkg::LEN_CONTROL);
        frame_body.push_back(rcsfd_pkg::TYPE_CONTROL);
        for (int i = 0; i < rcsfd_pkg::PAY_BYTES; i++)
            frame_body.push_back(fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom));
        frame_body.push_back(8'($urandom));
        frame_body.push_back(8'($urandom));
    endtask

    task automatic build_downlink(input logic [7:0] prim);
        frame_body.delete();
        frame_body.push_back(rcsfd_pkg::LEN_DOWNLINK);
        frame_body.push_back(rcsfd_pkg::TYPE_DOWNLINK);
        frame_body.push_back(prim);
        repeat (int'(rcsfd_pkg::LEN_DOWNLINK) - 2)
            frame_body.push_back(8'($urandom));
    endtask

    task automatic close_frame(input logic corrupt);
        int total;
        int folded;
        int check;
        total = 0;
        check = 0;
        foreach (frame_body[i])
            total += frame_body[i];
        for (int c = 0; c < 256; c++) begin
            folded = (total + c) & 16'hFFFF;
            folded = (folded & 8'hFF) + (folded >> 8);
            if (folded == rcsfd_pkg::SUM_GOOD)
                check = c;
        end
        if (corrupt)
            check = check ^ $urandom_range(1, 255);
        frame_body.push_back(8'(check));
        frame_body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : rcsfd_pkg::HEAD_BYTE);
    endtask

    task automatic run_random(input int n_bytes);
        int           target;
        int           pick;
        int           keep;
        t_frame_shape shape;
        logic         long_head;
        target = bytes_queued + n_bytes;
        while (bytes_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      shape = SHAPE_CONTROL;
            else if (pick < 55) shape = SHAPE_POLL;
            else if (pick < 60) shape = SHAPE_DOWNLINK;
            else if (pick < 70) shape = SHAPE_BAD_SUM;
            else if (pick < 75) shape = SHAPE_BAD_LEN;
            else if (pick < 80) shape = SHAPE_BAD_TYPE;
            else if (pick < 85) shape = SHAPE_UNKNOWN_TYPE;
            else if (pick < 93) shape = SHAPE_CUT;
            else                shape = SHAPE_NOISE;
            long_head = cut_pending || $urandom_range(0, 2) == 0;
            cut_pending = 1'b0;
            case (shape)
                SHAPE_CONTROL: begin
                    build_control();
                    close_frame(1'b0);
                end
                SHAPE_POLL: begin
                    build_downlink($urandom_range(0, 1) ? rcsfd_pkg::PRIM_POLL_ALT
                                                        : rcsfd_pkg::PRIM_POLL);
                    close_frame(1'b0);
                end
                SHAPE_DOWNLINK: begin
                    build_downlink(8'($urandom));
                    close_frame(1'b0);
                end
                SHAPE_BAD_SUM: begin
                    if ($urandom_range(0, 1))
                        build_control();
                    else
                        build_downlink(rcsfd_pkg::PRIM_POLL);
                    close_frame(1'b1);
                end
                SHAPE_BAD_LEN: begin
                    frame_body.delete();
                    repeat ($urandom_range(1, 4))
                        frame_body.push_back(8'($urandom));
                end
                SHAPE_BAD_TYPE: begin
                    frame_body.delete();
                    if ($urandom_range(0, 1)) begin
                        frame_body.push_back(rcsfd_pkg::LEN_CONTROL);
                        frame_body.push_back(rcsfd_pkg::TYPE_DOWNLINK);
                    end else begin
                        frame_body.push_back(rcsfd_pkg::LEN_DOWNLINK);
                        frame_body.push_back(rcsfd_pkg::TYPE_CONTROL);
                    end
                    repeat ($urandom_range(0, 3))
                        frame_body.push_back(8'($urandom));
                end
                SHAPE_UNKNOWN_TYPE: begin
                    frame_body.delete();
                    frame_body.push_back($urandom_range(0, 1) ? rcsfd_pkg::LEN_CONTROL
                                                              : rcsfd_pkg::LEN_DOWNLINK);
                    frame_body.push_back(8'($urandom_range(2, 255)));
                    repeat (rcsfd_pkg::FRAME_BYTES - 3)
                        frame_body.push_back(8'($urandom));
                end
                SHAPE_CUT: begin
                    build_control();
                    close_frame(1'b0);
                    keep = $urandom_range(1, frame_body.size() - 2);
                    while (frame_body.size() > keep)
                        void'(frame_body.pop_back());
                    cut_pending = 1'b1;
                end
                SHAPE_NOISE: begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                end
            endcase
            if (shape != SHAPE_NOISE)
                queue_framed(long_head);
        end
    endtask

    task automatic wait_idle();
        while (bytes_taken != bytes_queued || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_gap(input logic [15:0] gap);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rcsfd_pkg::ADDR_W'(4 * int'(rcsfd_pkg::REG_FRAME_GAP));
        pwdata <= {16'($urandom), gap};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_gap = gap;
    endtask

    initial begin
        t_rx_byte first;
        foreach (frame_buf[i])
            frame_buf[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // stray bytes before any header, at both ends of the time range
        first.value = 8'h00;
        first.stamp = 32'h0000_0000;
        byte_feed.push_back(first);
        first.value = 8'hFF;
        first.stamp = 32'hFFFF_FFFF;
        byte_feed.push_back(first);
        bytes_queued += 2;
        gen_stamp = 32'hFFFF_FFFF;
        // bad length, then length and type disagreeing
        frame_body = {8'h33};
        queue_framed(1'b1);
        frame_body = {rcsfd_pkg::LEN_DOWNLINK, rcsfd_pkg::TYPE_CONTROL};
        queue_framed(1'b1);
        // poll carrying a header byte and an escape byte in its data
        build_downlink(rcsfd_pkg::PRIM_POLL_ALT);
        frame_body[4] = rcsfd_pkg::HEAD_BYTE;
        frame_body[5] = rcsfd_pkg::ESC_BYTE;
        close_frame(1'b0);
        queue_framed(1'b1);

        run_random(118);
        wait_idle();
        write_frame_gap(16'd0);
        run_random(20);
        wait_idle();
        write_frame_gap(16'hFFFF);
        gen_stamp = 32'hFFFF_FF00;
        run_random(78);
        wait_idle();
        write_frame_gap(16'd1);
        run_random(52);
        wait_idle();
        write_frame_gap(16'($urandom_range(2, 65534)));
        run_random(72);
        wait_idle();

        if (pending_results.size() != 0)
            log_failure("missing result", pending_results[0], '0);
        if (fail_count == 0)
            $display("rc_stuffed_frame_decoder regression: pass");
        else
            $display("rc_stuffed_frame_decoder regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/rcsfd_pkg.sv
hdl/rcsfd_front.sv
hdl/rcsfd_queue.sv
hdl/rcsfd_back.sv
hdl/rc_stuffed_frame_decoder.sv
hdl/rcsfd_checker.sv
tb/tb.sv
